@@ rtl/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg
// Shared widths, operation codes and constants of the stride task scheduler.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int FUNC_W   = 2;
  localparam int SLOT_FW  = 4;
  localparam int PRIO_W   = 16;
  localparam int STRIDE_W = 32;
  localparam int SLICE_W  = 8;
  localparam int COUNT_W  = 5;
  localparam int QUO_W    = 31;
  localparam int DCNT_W   = 5;

  localparam int NUM_SLOTS_DEF = 16;

  localparam logic [FUNC_W-1:0] FN_ENQUEUE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DEQUEUE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_PICK    = 2'd2;
  localparam logic [FUNC_W-1:0] FN_TICK    = 2'd3;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd5;
  localparam logic [QUO_W-1:0]   STRIDE_BIG  = 31'h7FFF_FFFF;
  localparam logic [DCNT_W-1:0]  DIV_LAST    = DCNT_W'(QUO_W - 1);

endpackage

@@ rtl/sts_req_if.sv @@
// ----------------------------------------------------------------------------
// sts_req_if
// Request channel: one operation word per handshake.
// ----------------------------------------------------------------------------
interface sts_req_if;
  import sts_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SLOT_FW-1:0]  task_slot;
  logic [PRIO_W-1:0]   task_priority;

  modport source (output valid, output func, output task_slot, output task_priority,
                  input ready);
  modport sink   (input valid, input func, input task_slot, input task_priority,
                  output ready);
endinterface

@@ rtl/sts_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sts_rsp_if
// Response channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface sts_rsp_if;
  import sts_pkg::*;

  logic                valid;
  logic                ready;
  logic                pick_valid;
  logic [SLOT_FW-1:0]  picked_slot;
  logic                resched_needed;
  logic [COUNT_W-1:0]  queued_total;

  modport source (output valid, output pick_valid, output picked_slot,
                  output resched_needed, output queued_total, input ready);
  modport sink   (input valid, input pick_valid, input picked_slot,
                  input resched_needed, input queued_total, output ready);
endinterface

@@ rtl/stride_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// stride_task_scheduler
// Stride scheduler over a table of task slots with a shared serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation word (enqueue, dequeue, pick next, tick) and
//   rsp returns exactly one result word per request, in order. cfg_we with
//   cfg_data writes slice_length; write it only while the block is idle.
//   req.ready is high only while the sequencer is idle, so one word is in
//   work at a time. Enqueue and dequeue go straight to the output stage;
//   tick first does one slice table read; pick runs the stride scan,
//   which reads one slot per cycle, then a restoring divider forms
//   0x7FFFFFFF / priority one quotient bit a cycle.
//   An empty pick skips the divider.
//   The result sits in an output register, so the next request is accepted
//   while rsp is stalled; that request then waits in its final state until
//   the output register frees.
//   Reset (rst, synchronous) empties the queue, clears strides and slices
//   and loads slice_length with 5; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stride_task_scheduler #(
  parameter int NUM_SLOTS = sts_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  sts_req_if.sink                      req,
  sts_rsp_if.source                    rsp,
  input  logic                         cfg_we,
  input  logic [sts_pkg::SLICE_W-1:0]  cfg_data
);
  import sts_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_TICK, S_SCAN, S_PRIO, S_DIV, S_ADD, S_DONE
  } state_t;

  state_t state;

  logic [STRIDE_W-1:0] stride_mem [NUM_SLOTS];
  logic [PRIO_W-1:0]   prio_mem   [NUM_SLOTS];
  logic [SLICE_W-1:0]  slice_mem  [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] in_queue;
  logic [NUM_SLOTS-1:0] stride_ok;
  logic [NUM_SLOTS-1:0] slice_ok;
  logic [COUNT_W-1:0]   queue_count;
  logic [SLICE_W-1:0]   slice_length;

  logic [SLOT_W-1:0]    lat_slot;
  logic                 lat_ok;
  logic [SLOT_W-1:0]    rd_idx;
  logic                 rd_more;
  logic [SLOT_W-1:0]    cmp_idx;
  logic                 cmp_vld;
  logic [STRIDE_W-1:0]  stride_rd;
  logic                 found;
  logic [SLOT_W-1:0]    best;
  logic [STRIDE_W-1:0]  best_stride;
  logic [PRIO_W-1:0]    prio_rd;
  logic [SLICE_W-1:0]   slice_rd;
  logic [PRIO_W-1:0]    rem;
  logic [QUO_W-1:0]     quo;
  logic [DCNT_W-1:0]    div_cnt;

  logic                 res_pick;
  logic [SLOT_W-1:0]    res_slot;
  logic                 res_resched;

  logic                 out_valid;
  logic                 out_pick;
  logic [SLOT_FW-1:0]   out_slot;
  logic                 out_resched;
  logic [COUNT_W-1:0]   out_total;

  // Combinational helpers
  logic                 in_ok;
  logic [SLOT_W-1:0]    in_addr;
  logic [STRIDE_W-1:0]  stride_cur;
  logic [STRIDE_W-1:0]  stride_diff;
  logic                 take;
  logic [PRIO_W-1:0]    divisor;
  logic [PRIO_W:0]      trial;
  logic                 ge;
  logic [SLICE_W-1:0]   slice_cur;
  logic [SLICE_W-1:0]   slice_nxt;
  logic                 out_free;

  always_comb begin
    in_ok       = {{(32 - SLOT_FW){1'b0}}, req.task_slot} < 32'(NUM_SLOTS);
    in_addr     = SLOT_W'(req.task_slot);
    stride_cur  = stride_ok[cmp_idx] ? stride_rd : '0;
    stride_diff = stride_cur - best_stride;
    take        = in_queue[cmp_idx] && (!found || stride_diff[STRIDE_W-1]);
    divisor     = (prio_rd == '0) ? PRIO_W'(1) : prio_rd;
    trial       = {rem, STRIDE_BIG[DIV_LAST - div_cnt]};
    ge          = trial >= {1'b0, divisor};
    slice_cur   = slice_ok[lat_slot] ? slice_rd : '0;
    slice_nxt   = (slice_cur != '0) ? slice_cur - SLICE_W'(1) : '0;
    out_free    = !out_valid || rsp.ready;
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.pick_valid     = out_pick;
  assign rsp.picked_slot    = out_slot;
  assign rsp.resched_needed = out_resched;
  assign rsp.queued_total   = out_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_queue     <= '0;
      stride_ok    <= '0;
      slice_ok     <= '0;
      queue_count  <= '0;
      slice_length <= SLICE_RESET;
      out_valid    <= 1'b0;
      rd_more      <= 1'b0;
      cmp_vld      <= 1'b0;
      found        <= 1'b0;
    end else begin
      if (cfg_we) begin
        slice_length <= cfg_data;
      end
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            lat_slot    <= in_addr;
            lat_ok      <= in_ok;
            res_pick    <= 1'b0;
            res_slot    <= '0;
            res_resched <= 1'b0;
            unique case (req.func)
              FN_ENQUEUE: begin
                if (in_ok) begin
                  prio_mem[in_addr]  <= (req.task_priority == '0) ? PRIO_W'(1)
                                                                  : req.task_priority;
                  slice_mem[in_addr] <= slice_length;
                  slice_ok[in_addr]  <= 1'b1;
                  if (!in_queue[in_addr]) begin
                    in_queue[in_addr] <= 1'b1;
                    queue_count       <= queue_count + COUNT_W'(1);
                  end
                end
                state <= S_DONE;
              end
              FN_DEQUEUE: begin
                if (in_ok && in_queue[in_addr]) begin
                  in_queue[in_addr] <= 1'b0;
                  queue_count       <= queue_count - COUNT_W'(1);
                end
                state <= S_DONE;
              end
              FN_PICK: begin
                rd_idx  <= '0;
                rd_more <= 1'b1;
                cmp_vld <= 1'b0;
                found   <= 1'b0;
                state   <= S_SCAN;
              end
              default: begin
                slice_rd <= slice_mem[in_addr];
                state    <= S_TICK;
              end
            endcase
          end
        end

        S_TICK: begin
          if (lat_ok) begin
            slice_mem[lat_slot] <= slice_nxt;
            res_resched         <= (slice_nxt == '0);
          end
          state <= S_DONE;
        end

        S_SCAN: begin
          // Read one slot, compare the one read last cycle
          if (rd_more) begin
            stride_rd <= stride_mem[rd_idx];
            cmp_idx   <= rd_idx;
            cmp_vld   <= 1'b1;
            if (rd_idx == LAST_SLOT) begin
              rd_more <= 1'b0;
            end else begin
              rd_idx <= rd_idx + SLOT_W'(1);
            end
          end else begin
            cmp_vld <= 1'b0;
          end
          if (cmp_vld) begin
            if (take) begin
              best        <= cmp_idx;
              best_stride <= stride_cur;
              found       <= 1'b1;
            end
            if (cmp_idx == LAST_SLOT) begin
              state <= S_PRIO;
            end
          end
        end

        S_PRIO: begin
          if (found) begin
            prio_rd <= prio_mem[best];
            rem     <= '0;
            quo     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            state <= S_DONE;
          end
        end

        S_DIV: begin
          rem     <= ge ? PRIO_W'(trial - {1'b0, divisor}) : PRIO_W'(trial);
          quo     <= {quo[QUO_W-2:0], ge};
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_cnt == DIV_LAST) begin
            state <= S_ADD;
          end
        end

        S_ADD: begin
          stride_mem[best] <= best_stride + {1'b0, quo};
          stride_ok[best]  <= 1'b1;
          res_pick         <= 1'b1;
          res_slot         <= best;
          state            <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_pick    <= res_pick;
            out_slot    <= SLOT_FW'(res_slot);
            out_resched <= res_resched;
            out_total   <= queue_count;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/sts_checker.sv @@
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks of the stride task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module sts_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         pick_valid,
  input logic [sts_pkg::SLOT_FW-1:0]  picked_slot,
  input logic [sts_pkg::COUNT_W-1:0]  queued_total
);
  import sts_pkg::*;

  // Hold a stalled result word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped while stalled");

  // One word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while a word is in work");

  // Idle straight after reset
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> req_ready)
    else $error("not idle after reset");

  a_slot_zero_on_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !pick_valid |-> picked_slot == '0)
    else $error("picked_slot set without a pick");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> queued_total <= COUNT_W'(16))
    else $error("queued_total beyond slot count");

endmodule

bind stride_task_scheduler sts_checker u_sts_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .pick_valid   (rsp.pick_valid),
  .picked_slot  (rsp.picked_slot),
  .queued_total (rsp.queued_total)
);
